FILE: design/lfu_pkg.sv
// shared types and constants for the lfu cache table
`timescale 1ns / 1ps
`default_nettype none

package lfu_pkg;

   // default number of cache slots
   localparam int SLOTS_DEF = 16;

   // field widths
   localparam int KEY_W   = 32;
   localparam int VAL_W   = 32;
   localparam int USE_W   = 32;
   localparam int STAMP_W = 64;
   localparam int CAP_W   = 5;

   // stream payload widths
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 72;
   localparam int RSP_PAD_W  = RSP_DATA_W - (1 + VAL_W + 1 + KEY_W);

   // register port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_CAPACITY = 1'b0;  // register select bit of paddr
   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   // saturation point of the use counters
   localparam logic [USE_W-1:0] USE_MAX = '1;

   // request commands
   localparam logic CMD_GET = 1'b0;
   localparam logic CMD_SET = 1'b1;

   // running search record passed along the cell chain
   typedef struct packed {
      logic               active;
      logic               cmd;
      logic [KEY_W-1:0]   key;
      logic [VAL_W-1:0]   value;
      logic               hit;
      logic [VAL_W-1:0]   hit_value;
      logic               vict_found;
      logic [KEY_W-1:0]   vict_key;
      logic [USE_W-1:0]   vict_count;
      logic [STAMP_W-1:0] vict_stamp;
      logic               free_found;
   } lfu_scan_type;

   // slot update broadcast to all cells
   typedef struct packed {
      logic               en;
      logic               fill;
      logic               set_value;
      logic [KEY_W-1:0]   key;
      logic [VAL_W-1:0]   value;
      logic [STAMP_W-1:0] stamp;
   } lfu_wr_type;

endpackage

`default_nettype wire

FILE: design/lfu_cell.sv
// one cache slot with its stage of the search chain
`timescale 1ns / 1ps
`default_nettype none

module lfu_cell
   import lfu_pkg::*;
#(
   parameter int SLOTS      = SLOTS_DEF,
   parameter int CELL_INDEX = 0
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire lfu_scan_type                           up_scan,
   input  wire logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] up_hit_idx,
   input  wire logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] up_vict_idx,
   input  wire logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] up_free_idx,
   input  wire logic [$clog2(SLOTS + 1)-1:0]           up_used,
   output lfu_scan_type                                dn_scan,
   output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] dn_hit_idx,
   output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] dn_vict_idx,
   output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] dn_free_idx,
   output logic [$clog2(SLOTS + 1)-1:0]                dn_used,
   input  wire lfu_wr_type                             wr_cmd,
   input  wire logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] wr_idx
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int NUM_W = $clog2(SLOTS + 1);
   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);

   // slot contents
   logic               valid_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [VAL_W-1:0]   value_ff;
   logic [USE_W-1:0]   count_ff;
   logic [STAMP_W-1:0] stamp_ff;

   // chain stage registers
   lfu_scan_type       scan_ff, scan_in;
   logic [IDX_W-1:0]   hit_idx_ff, hit_idx_in;
   logic [IDX_W-1:0]   vict_idx_ff, vict_idx_in;
   logic [IDX_W-1:0]   free_idx_ff, free_idx_in;
   logic [NUM_W-1:0]   used_ff, used_in;

   logic               is_match;
   logic               beats_victim;
   logic               wr_sel;

   // fold this slot into the running search record
   always_comb begin
      scan_in     = up_scan;
      hit_idx_in  = up_hit_idx;
      vict_idx_in = up_vict_idx;
      free_idx_in = up_free_idx;
      used_in     = up_used;
      is_match    = valid_ff && (key_ff == up_scan.key);
      beats_victim = !up_scan.vict_found
                  || (count_ff < up_scan.vict_count)
                  || ((count_ff == up_scan.vict_count) && (stamp_ff < up_scan.vict_stamp));
      if (up_scan.active) begin
         if (is_match && !up_scan.hit) begin
            scan_in.hit       = 1'b1;
            scan_in.hit_value = value_ff;
            hit_idx_in        = MY_IDX;
         end
         if (valid_ff) begin
            used_in = up_used + NUM_W'(1);
            if (beats_victim) begin
               scan_in.vict_found = 1'b1;
               scan_in.vict_key   = key_ff;
               scan_in.vict_count = count_ff;
               scan_in.vict_stamp = stamp_ff;
               vict_idx_in        = MY_IDX;
            end
         end else if (!up_scan.free_found) begin
            scan_in.free_found = 1'b1;
            free_idx_in        = MY_IDX;
         end
      end
   end

   assign wr_sel = wr_cmd.en && (wr_idx == MY_IDX);

   // chain stage and slot valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff.active <= 1'b0;
         valid_ff       <= 1'b0;
      end else begin
         scan_ff     <= scan_in;
         hit_idx_ff  <= hit_idx_in;
         vict_idx_ff <= vict_idx_in;
         free_idx_ff <= free_idx_in;
         used_ff     <= used_in;
         if (wr_sel && wr_cmd.fill) begin
            valid_ff <= 1'b1;
         end
      end
   end

   // slot payload update: fill a new entry or touch an existing one
   always_ff @(posedge clock) begin
      if (wr_sel) begin
         stamp_ff <= wr_cmd.stamp;
         if (wr_cmd.fill) begin
            key_ff   <= wr_cmd.key;
            value_ff <= wr_cmd.value;
            count_ff <= USE_W'(1);
         end else begin
            if (wr_cmd.set_value) begin
               value_ff <= wr_cmd.value;
            end
            if (count_ff != USE_MAX) begin
               count_ff <= count_ff + USE_W'(1);
            end
         end
      end
   end

   assign dn_scan     = scan_ff;
   assign dn_hit_idx  = hit_idx_ff;
   assign dn_vict_idx = vict_idx_ff;
   assign dn_free_idx = free_idx_ff;
   assign dn_used     = used_ff;

endmodule

`default_nettype wire

FILE: design/lfu_cache_table_top.sv
// lfu cache table: request sequencer, register port and chain of slot cells
// a request beat passes the slot cells in order, then the decision and the result registers
// a new request is taken only in the idle state, once the previous one has walked the chain
//   of slot cells one cell per cycle and has been decided and committed
// a request may be accepted while the previous result still waits on rsp
// reset clears slot valid bits, access clock and state at once; capacity returns to 16
`timescale 1ns / 1ps
`default_nettype none

module lfu_cache_table_top
   import lfu_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request stream
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,   // key[31:0], value[63:32]
   input  wire logic [0:0]            req_tuser,   // command[0]
   // result stream
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,   // hit[0], read_value[32:1],
                                                   // evicted[33], evicted_key[65:34]
   // register port
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0]      csr_prdata,
   output logic                       csr_pready
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int NUM_W = $clog2(SLOTS + 1);
   localparam int CMP_W = (NUM_W > CAP_W) ? NUM_W : CAP_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT
   } state_type;

   state_type            state_ff;
   logic [CAP_W-1:0]     cap_ff;
   logic [STAMP_W-1:0]   clk_ff;

   // decided update and pending result
   lfu_wr_type           wr_ff;
   logic [IDX_W-1:0]     wr_idx_ff;
   logic                 pend_hit_ff;
   logic [VAL_W-1:0]     pend_rd_ff;
   logic                 pend_ev_ff;
   logic [KEY_W-1:0]     pend_evk_ff;

   // result register
   logic                 rsp_valid_ff;
   logic                 rsp_hit_ff;
   logic [VAL_W-1:0]     rsp_rd_ff;
   logic                 rsp_ev_ff;
   logic [KEY_W-1:0]     rsp_evk_ff;

   // chain links
   lfu_scan_type         link_scan [SLOTS+1];
   logic [IDX_W-1:0]     link_hit_idx [SLOTS+1];
   logic [IDX_W-1:0]     link_vict_idx [SLOTS+1];
   logic [IDX_W-1:0]     link_free_idx [SLOTS+1];
   logic [NUM_W-1:0]     link_used [SLOTS+1];

   lfu_scan_type         tail;
   lfu_wr_type           wr_bus;
   logic                 req_go;
   logic                 out_free;
   logic                 commit_go;
   logic                 cap_zero;
   logic                 is_full;

   lfu_wr_type           dec_wr;
   logic [IDX_W-1:0]     dec_idx;
   logic                 dec_hit;
   logic [VAL_W-1:0]     dec_rd;
   logic                 dec_ev;
   logic [KEY_W-1:0]     dec_evk;

   // handshakes
   assign req_tready = (state_ff == ST_IDLE);
   assign req_go     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign commit_go  = (state_ff == ST_COMMIT) && out_free;

   // register port
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_CAPACITY) ? CSR_DATA_W'(cap_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready
                   && (csr_paddr[2] == REG_CAPACITY)) begin
         cap_ff <= csr_pwdata[CAP_W-1:0];
      end
   end

   // head of the chain: a fresh search record
   always_comb begin
      link_scan[0]        = '0;
      link_scan[0].active = req_go;
      link_scan[0].cmd    = req_tuser[0];
      link_scan[0].key    = req_tdata[KEY_W-1:0];
      link_scan[0].value  = req_tdata[KEY_W +: VAL_W];
   end
   assign link_hit_idx[0]  = '0;
   assign link_vict_idx[0] = '0;
   assign link_free_idx[0] = '0;
   assign link_used[0]     = '0;

   // one cell per slot
   for (genvar g = 0; g < SLOTS; g++) begin : g_cell
      lfu_cell #(
         .SLOTS      (SLOTS),
         .CELL_INDEX (g)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .up_scan     (link_scan[g]),
         .up_hit_idx  (link_hit_idx[g]),
         .up_vict_idx (link_vict_idx[g]),
         .up_free_idx (link_free_idx[g]),
         .up_used     (link_used[g]),
         .dn_scan     (link_scan[g+1]),
         .dn_hit_idx  (link_hit_idx[g+1]),
         .dn_vict_idx (link_vict_idx[g+1]),
         .dn_free_idx (link_free_idx[g+1]),
         .dn_used     (link_used[g+1]),
         .wr_cmd      (wr_bus),
         .wr_idx      (wr_idx_ff)
      );
   end

   assign tail     = link_scan[SLOTS];
   assign cap_zero = (cap_ff == '0);
   assign is_full  = (CMP_W'(link_used[SLOTS]) >= CMP_W'(cap_ff))
                  || (link_used[SLOTS] == NUM_W'(SLOTS));

   // decide hit, eviction and slot update from the finished search
   always_comb begin
      dec_hit          = 1'b0;
      dec_rd           = (tail.cmd == CMD_GET) ? '1 : '0;
      dec_ev           = 1'b0;
      dec_evk          = '0;
      dec_idx          = link_hit_idx[SLOTS];
      dec_wr           = '0;
      dec_wr.key       = tail.key;
      dec_wr.value     = tail.value;
      dec_wr.stamp     = clk_ff;
      if (!cap_zero) begin
         if (tail.hit) begin
            dec_hit   = 1'b1;
            dec_wr.en = 1'b1;
            if (tail.cmd == CMD_SET) begin
               dec_wr.set_value = 1'b1;
            end else begin
               dec_rd = tail.hit_value;
            end
         end else if (tail.cmd == CMD_SET) begin
            if (is_full && tail.vict_found) begin
               dec_ev      = 1'b1;
               dec_evk     = tail.vict_key;
               dec_wr.en   = 1'b1;
               dec_wr.fill = 1'b1;
               dec_idx     = link_vict_idx[SLOTS];
            end else if (tail.free_found) begin
               dec_wr.en   = 1'b1;
               dec_wr.fill = 1'b1;
               dec_idx     = link_free_idx[SLOTS];
            end
         end
      end
   end

   // update goes to the cells only on the commit edge
   always_comb begin
      wr_bus    = wr_ff;
      wr_bus.en = wr_ff.en && commit_go;
   end

   // sequencer, access clock and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         clk_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_go) begin
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (tail.active) begin
                  wr_ff       <= dec_wr;
                  wr_idx_ff   <= dec_idx;
                  pend_hit_ff <= dec_hit;
                  pend_rd_ff  <= dec_rd;
                  pend_ev_ff  <= dec_ev;
                  pend_evk_ff <= dec_evk;
                  state_ff    <= ST_COMMIT;
               end
            end
            ST_COMMIT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_hit_ff   <= pend_hit_ff;
                  rsp_rd_ff    <= pend_rd_ff;
                  rsp_ev_ff    <= pend_ev_ff;
                  rsp_evk_ff   <= pend_evk_ff;
                  if (wr_ff.en) begin
                     clk_ff <= clk_ff + STAMP_W'(1);
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {RSP_PAD_W'(0), rsp_evk_ff, rsp_ev_ff, rsp_rd_ff, rsp_hit_ff};

`ifndef SYNTHESIS
   // a new request is not taken while one is in flight
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_go |=> !req_tready)
      else $error("request accepted while previous one in flight");

   // the search record reaches the end of the chain only during a search
   a_tail_in_scan: assert property (@(posedge clock) disable iff (reset)
      tail.active |-> (state_ff == ST_SCAN))
      else $error("search record at chain end outside search");

   // the access clock moves only when a slot is touched
   a_clock_steady: assert property (@(posedge clock) disable iff (reset)
      !(commit_go && wr_ff.en) |=> $stable(clk_ff))
      else $error("access clock moved without a slot update");

   // an eviction never comes with a hit
   a_evict_no_hit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ev_ff) |-> !rsp_hit_ff)
      else $error("eviction reported together with hit");
`endif

endmodule

`default_nettype wire

FILE: sim/lfu_cache_checker.sv
// checker for the lfu cache table: watches the streams and register port, predicts and compares
`timescale 1ns / 1ps

module lfu_cache_checker
   import lfu_pkg::*;
#(
   parameter int                    SLOTS    = SLOTS_DEF,
   parameter logic [CSR_ADDR_W-1:0] CAP_ADDR = '0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // key[31:0], value[63:32]
   input  logic [0:0]            req_tuser,   // command[0]
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,   // hit[0], read_value[32:1],
                                              // evicted[33], evicted_key[65:34]
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic                  csr_pready,
   output int                    pending,
   output int                    failures
);

   typedef struct packed {
      logic             hit;
      logic [VAL_W-1:0] read_value;
      logic             evicted;
      logic [KEY_W-1:0] evicted_key;
   } cache_reply_type;

   // shadow copy of the cache contents
   logic               entry_valid [SLOTS];
   logic [KEY_W-1:0]   entry_key   [SLOTS];
   logic [VAL_W-1:0]   entry_value [SLOTS];
   logic [USE_W-1:0]   entry_uses  [SLOTS];
   logic [STAMP_W-1:0] entry_stamp [SLOTS];
   logic [STAMP_W-1:0] access_count;
   logic [CAP_W-1:0]   cap_reg;

   cache_reply_type cache_replies [$];

   // count one more use (saturating) and stamp the entry
   function automatic void touch_entry(int s);
      if (entry_uses[s] != USE_MAX)
         entry_uses[s] = entry_uses[s] + 1'b1;
      entry_stamp[s] = access_count;
      access_count   = access_count + 1'b1;
   endfunction

   // apply one request to the shadow cache and return its reply
   function automatic cache_reply_type cache_access(logic cmd, logic [KEY_W-1:0] k,
                                                    logic [VAL_W-1:0] v);
      cache_reply_type r;
      int eff_cap;
      int found;
      int free_idx;
      int victim;
      int used;
      int target;
      r = '0;
      eff_cap = (int'(cap_reg) > SLOTS) ? SLOTS : int'(cap_reg);
      found = -1;
      for (int i = 0; i < SLOTS; i++)
         if (found < 0 && entry_valid[i] && entry_key[i] == k)
            found = i;

      if (cmd == CMD_GET) begin
         r.read_value = '1;
         if (eff_cap != 0 && found >= 0) begin
            r.hit        = 1'b1;
            r.read_value = entry_value[found];
            touch_entry(found);
         end
      end else if (eff_cap != 0) begin
         if (found >= 0) begin
            r.hit              = 1'b1;
            entry_value[found] = v;
            touch_entry(found);
         end else begin
            // lowest free slot, and the victim with lowest (uses, stamp)
            used     = 0;
            free_idx = -1;
            victim   = -1;
            for (int i = 0; i < SLOTS; i++) begin
               if (entry_valid[i]) begin
                  used++;
                  if (victim < 0 || entry_uses[i] < entry_uses[victim] ||
                      (entry_uses[i] == entry_uses[victim] &&
                       entry_stamp[i] < entry_stamp[victim]))
                     victim = i;
               end else if (free_idx < 0) begin
                  free_idx = i;
               end
            end
            target = free_idx;
            if (used >= eff_cap && victim >= 0) begin
               r.evicted     = 1'b1;
               r.evicted_key = entry_key[victim];
               target        = victim;
            end
            if (target >= 0) begin
               entry_valid[target] = 1'b1;
               entry_key[target]   = k;
               entry_value[target] = v;
               entry_uses[target]  = '0;
               touch_entry(target);
            end
         end
      end
      return r;
   endfunction

   // sample every handshake at the clock edge
   always @(posedge clock) begin
      cache_reply_type got;
      cache_reply_type want;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            entry_valid[i] = 1'b0;
            entry_key[i]   = '0;
            entry_value[i] = '0;
            entry_uses[i]  = '0;
            entry_stamp[i] = '0;
         end
         access_count = '0;
         cap_reg      = CAP_RESET;
         cache_replies.delete();
         pending = 0;
      end else begin
         // register write
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr == CAP_ADDR)
            cap_reg = csr_pwdata[CAP_W-1:0];

         // result beat against the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            got.hit         = rsp_tdata[0];
            got.read_value  = rsp_tdata[VAL_W:1];
            got.evicted     = rsp_tdata[VAL_W+1];
            got.evicted_key = rsp_tdata[VAL_W+KEY_W+1:VAL_W+2];
            if (cache_replies.size() == 0) begin
               $error("result beat with no request outstanding");
               failures++;
            end else begin
               want = cache_replies[0];
               cache_replies.delete(0);
               if (got.hit !== want.hit) begin
                  $error("hit: expected %0d, actual %0d", want.hit, got.hit);
                  failures++;
               end
               if (got.read_value !== want.read_value) begin
                  $error("read_value: expected %0d, actual %0d",
                         $signed(want.read_value), $signed(got.read_value));
                  failures++;
               end
               if (got.evicted !== want.evicted) begin
                  $error("evicted: expected %0d, actual %0d", want.evicted, got.evicted);
                  failures++;
               end
               if (got.evicted_key !== want.evicted_key) begin
                  $error("evicted_key: expected %0d, actual %0d",
                         $signed(want.evicted_key), $signed(got.evicted_key));
                  failures++;
               end
            end
         end

         // request beat
         if (req_tvalid && req_tready)
            cache_replies.insert(cache_replies.size(),
                                 cache_access(req_tuser[0], req_tdata[KEY_W-1:0],
                                              req_tdata[KEY_W +: VAL_W]));
         pending = cache_replies.size();
      end
   end

endmodule

FILE: sim/lfu_cache_table_top_tb.sv
// testbench top for the lfu cache table: request stimulus, capacity writes and verdict
`timescale 1ns / 1ps

module lfu_cache_table_top_tb;
   import lfu_pkg::*;

   localparam int SLOTS = SLOTS_DEF;
   localparam logic [CSR_ADDR_W-1:0] CAP_ADDR = '0;   // capacity register
   localparam int IDLE_LIMIT = 4000;
   localparam int PHASES     = 10;
   localparam int PHASE_LEN  = 85;
   localparam int POOL_MAX   = 24;

   logic                  clock;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;   // key[31:0], value[63:32]
   logic [0:0]            req_tuser   = '0;   // command[0]
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;          // hit[0], read_value[32:1],
                                              // evicted[33], evicted_key[65:34]
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int pending;
   int failures;
   int idle_cycles = 0;
   int stall_left  = 0;
   bit req_gaps    = 1'b0;
   bit rsp_stalls  = 1'b0;

   logic [KEY_W-1:0] key_pool [POOL_MAX];

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   lfu_cache_table_top #(.SLOTS(SLOTS)) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   lfu_cache_checker #(.SLOTS(SLOTS), .CAP_ADDR(CAP_ADDR)) u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .pending     (pending),
      .failures    (failures)
   );

   // result side back-pressure in random bursts
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (rsp_stalls && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 5);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // watchdog on cycles without any beat
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      while (idle_cycles < IDLE_LIMIT)
         @(posedge clock);
      $display("TB_ERROR");
      $finish;
   end

   // one request beat, valid stays high afterwards unless a gap follows
   task automatic send_request(input logic cmd, input logic [KEY_W-1:0] k,
                               input logic [VAL_W-1:0] v);
      if (req_gaps && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {v, k};
      req_tuser  <= cmd;
      do @(posedge clock); while (!req_tready);
   endtask

   // hold off requests until every result has come back
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // setup and access cycle on the register port
   task automatic write_capacity(input logic [CAP_W-1:0] cap);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CAP_ADDR;
      csr_pwdata  <= CSR_DATA_W'(cap);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      logic             cmd;
      logic [KEY_W-1:0] k;
      logic [VAL_W-1:0] v;
      logic [CAP_W-1:0] cap;
      int               pool_n;

      // fixed extremes at the head of the key pool, random keys after them
      key_pool[0] = 32'h8000_0000;
      key_pool[1] = 32'h7FFF_FFFF;
      key_pool[2] = 32'h0000_0000;
      key_pool[3] = 32'hFFFF_FFFF;
      for (int i = 4; i < POOL_MAX; i++)
         key_pool[i] = $urandom;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: extreme keys and values at reset capacity
      send_request(CMD_GET, 32'h0000_0000, 32'h0000_0000);   // miss on empty cache
      send_request(CMD_SET, 32'h7FFF_FFFF, 32'h8000_0000);
      send_request(CMD_SET, 32'h8000_0000, 32'h7FFF_FFFF);
      send_request(CMD_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(CMD_SET, 32'h0000_0000, 32'h0000_0000);
      send_request(CMD_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_request(CMD_GET, 32'h8000_0000, 32'h0000_0000);
      send_request(CMD_SET, 32'h8000_0000, 32'h1234_5678);   // update of a present key
      send_request(CMD_GET, 32'h0000_0001, 32'h0000_0000);   // miss with entries stored
      send_request(CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000);

      // capacity dropped below occupancy: one eviction per new key
      wait_for_results();
      write_capacity(5'd1);
      send_request(CMD_SET, 32'h0000_0001, 32'hA5A5_A5A5);
      send_request(CMD_GET, 32'h0000_0001, 32'h0000_0000);
      send_request(CMD_SET, 32'h0000_0002, 32'h5A5A_5A5A);
      send_request(CMD_GET, 32'h8000_0000, 32'h0000_0000);

      // capacity zero: sets store nothing, gets miss on stored keys
      wait_for_results();
      write_capacity(5'd0);
      send_request(CMD_SET, 32'h0000_0003, 32'h0000_0005);
      send_request(CMD_GET, 32'h8000_0000, 32'h0000_0000);
      send_request(CMD_GET, 32'h0000_0002, 32'h0000_0000);

      // capacity above the slot count
      wait_for_results();
      write_capacity(5'd31);
      for (int i = 0; i < 8; i++)
         send_request(CMD_SET, 32'h0000_0100 + i, $urandom);

      // random phases over a range of capacities
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: cap = 5'd16;
            1: cap = 5'd1;
            2: cap = 5'd0;
            3: cap = 5'd17;
            4: cap = 5'd2;
            5: cap = 5'($urandom_range(0, 31));
            6: cap = 5'd8;
            7: cap = 5'd31;
            8: cap = 5'd4;
            default: cap = 5'd16;
         endcase
         wait_for_results();
         write_capacity(cap);

         // idling in most phases, none in phases 1, 4 and 7 or in the last one
         req_gaps   = (phase < PHASES - 1) && (phase % 3 != 1);
         rsp_stalls = req_gaps;

         // key pool a little larger than the capacity, to mix hits and evictions
         pool_n = (int'(cap) > SLOTS ? SLOTS : int'(cap)) + 4;
         if (pool_n < 6)
            pool_n = 6;
         for (int i = 4; i < POOL_MAX; i++)
            if ($urandom_range(0, 1) == 1)
               key_pool[i] = $urandom;

         for (int n = 0; n < PHASE_LEN; n++) begin
            cmd = ($urandom_range(0, 1) == 1) ? CMD_SET : CMD_GET;
            k   = ($urandom_range(0, 6) == 0) ? KEY_W'($urandom)
                                              : key_pool[$urandom_range(0, pool_n - 1)];
            v   = ($urandom_range(0, 9) == 0) ? key_pool[$urandom_range(0, 3)]
                                              : VAL_W'($urandom);
            send_request(cmd, k, v);
         end
      end

      // drain and let the pipeline settle
      wait_for_results();
      repeat (SLOTS + 8) @(posedge clock);
      if (failures == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
